/* hw/rtl/yqr_pkg.sv */
// ============================================================================
// yqr_pkg
// Shared types and constants of the 4:2:0 quad to RGB converter.
// ============================================================================
package yqr_pkg;

    // Arithmetic widths.
    localparam int SAMPLE_W  = 10;
    localparam int PIX_W     = 8;
    localparam int OFF_W     = 11;
    localparam int COEF_W    = 19;
    localparam int PROD_W    = OFF_W + COEF_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int FRAC_BITS = 16;
    localparam int REG_IDX_W = 3;

    typedef logic [SAMPLE_W-1:0]      sample_t;
    typedef logic [PIX_W-1:0]         pix_t;
    typedef logic signed [OFF_W-1:0]  off_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // Offsets and limits.
    localparam off_t CHROMA_ZERO         = 11'sd128;
    localparam off_t LUMA_OFFSET_LIMITED = 11'sd16;
    localparam off_t LUMA_OFFSET_FULL    = 11'sd0;
    localparam pix_t PIX_MAX             = 8'd255;
    localparam pix_t PIX_MIN             = 8'd0;

    // Coefficient values after reset (BT.601 limited range).
    localparam coef_t COEF_LUMA_RST       = 19'sd76309;
    localparam coef_t COEF_V_TO_RED_RST   = 19'sd104597;
    localparam coef_t COEF_U_TO_GREEN_RST = -19'sd25675;
    localparam coef_t COEF_V_TO_GREEN_RST = -19'sd53279;
    localparam coef_t COEF_U_TO_BLUE_RST  = 19'sd132201;

    // Register indexes of the configuration port.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_FULL_RANGE      = 3'd0,
        REG_TEN_BIT_MODE    = 3'd1,
        REG_COEF_LUMA       = 3'd2,
        REG_COEF_V_TO_RED   = 3'd3,
        REG_COEF_U_TO_GREEN = 3'd4,
        REG_COEF_V_TO_GREEN = 3'd5,
        REG_COEF_U_TO_BLUE  = 3'd6
    } reg_idx_t;

    // Payload of the configuration write channel.
    typedef struct packed {
        reg_idx_t            index;
        logic [COEF_W-1:0]   value;
    } cfg_wr_t;

    // Current register settings.
    typedef struct packed {
        logic  full_range;
        logic  ten_bit_mode;
        coef_t coef_luma;
        coef_t coef_v_to_red;
        coef_t coef_u_to_green;
        coef_t coef_v_to_green;
        coef_t coef_u_to_blue;
    } cfg_t;

    // One input quad.
    typedef struct packed {
        sample_t luma_top_left;
        sample_t luma_top_right;
        sample_t luma_bottom_left;
        sample_t luma_bottom_right;
        sample_t chroma_u;
        sample_t chroma_v;
    } quad_t;

    // One result: four RGB pixels.
    typedef struct packed {
        pix_t red_top_left;
        pix_t green_top_left;
        pix_t blue_top_left;
        pix_t red_top_right;
        pix_t green_top_right;
        pix_t blue_top_right;
        pix_t red_bottom_left;
        pix_t green_bottom_left;
        pix_t blue_bottom_left;
        pix_t red_bottom_right;
        pix_t green_bottom_right;
        pix_t blue_bottom_right;
    } rgb_t;

    // Offset samples; luma index 0 is top left, then top right, bottom left,
    // bottom right.
    typedef struct packed {
        off_t [3:0] y;
        off_t       u;
        off_t       v;
    } prep_t;

    // Products of the multiplier stage.
    typedef struct packed {
        prod_t [3:0] y;
        prod_t       vr;
        prod_t       ug;
        prod_t       vg;
        prod_t       ub;
    } prod_set_t;

    // Per channel sums before scaling.
    typedef struct packed {
        sum_t [3:0] r;
        sum_t [3:0] g;
        sum_t [3:0] b;
    } sum_set_t;

endpackage

/* hw/rtl/yqr_stream_if.sv */
// ============================================================================
// yqr_stream_if
// Valid/ready channel carrying one request of a chosen payload type.
// ============================================================================
interface yqr_stream_if #(
    parameter type data_t = logic
) ();

    logic  valid;
    logic  ready;
    data_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

/* hw/rtl/yuv420_quad_to_rgb.sv */
// ============================================================================
// yuv420_quad_to_rgb
// Converts one 4:2:0 quad (four luma, one U, one V) into four RGB pixels.
// ============================================================================
// Flow: a quad taken into the offset register moves on through the multiply and
// sum registers into the output register. Throughput: one quad per cycle unless
// rgb_out stalls; the four register stages (offset, multiply, sum, saturate)
// each take a new quad whenever they empty or move on.
// Reset: all stage valid bits clear and the configuration registers return to
// their documented defaults at once; there is no clearing pass.
module yuv420_quad_to_rgb
    import yqr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    yqr_stream_if.sink   quad_in,
    yqr_stream_if.source rgb_out,
    yqr_stream_if.sink   cfg_wr
);

    cfg_t cfg_set;

    yqr_stream_if #(.data_t(prep_t))     prep_ch ();
    yqr_stream_if #(.data_t(prod_set_t)) prod_ch ();

    // Configuration registers.
    yqr_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_wr (cfg_wr),
        .cfg    (cfg_set)
    );

    // Stage one: offsets.
    yqr_prep u_prep (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_set),
        .src   (quad_in),
        .dst   (prep_ch.source)
    );

    // Stage two: products.
    yqr_mult u_mult (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_set),
        .src   (prep_ch.sink),
        .dst   (prod_ch.source)
    );

    // Stages three and four: sums and saturation.
    yqr_post u_post (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (prod_ch.sink),
        .dst   (rgb_out)
    );

`ifndef SYNTH
    // A free output side must let a quad in, whatever the pipeline holds.
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_out.ready |-> quad_in.ready)
        else $error("input stalled while output is free");
`endif

endmodule

/* hw/rtl/yqr_cfg_regs.sv */
// ============================================================================
// yqr_cfg_regs
// Configuration register file written through its own request channel.
// ============================================================================
module yqr_cfg_regs
    import yqr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    yqr_stream_if.sink   cfg_wr,
    output cfg_t         cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_wr.ready = 1'b1;

    // Decode the register index; an index beyond the list is ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr.valid)
        begin
            unique case (cfg_wr.data.index)
                REG_FULL_RANGE:      cfg_next.full_range      = cfg_wr.data.value[0];
                REG_TEN_BIT_MODE:    cfg_next.ten_bit_mode    = cfg_wr.data.value[0];
                REG_COEF_LUMA:       cfg_next.coef_luma       = coef_t'(cfg_wr.data.value);
                REG_COEF_V_TO_RED:   cfg_next.coef_v_to_red   = coef_t'(cfg_wr.data.value);
                REG_COEF_U_TO_GREEN: cfg_next.coef_u_to_green = coef_t'(cfg_wr.data.value);
                REG_COEF_V_TO_GREEN: cfg_next.coef_v_to_green = coef_t'(cfg_wr.data.value);
                REG_COEF_U_TO_BLUE:  cfg_next.coef_u_to_blue  = coef_t'(cfg_wr.data.value);
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with the documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_range      <= 1'b0;
            cfg_reg.ten_bit_mode    <= 1'b0;
            cfg_reg.coef_luma       <= COEF_LUMA_RST;
            cfg_reg.coef_v_to_red   <= COEF_V_TO_RED_RST;
            cfg_reg.coef_u_to_green <= COEF_U_TO_GREEN_RST;
            cfg_reg.coef_v_to_green <= COEF_V_TO_GREEN_RST;
            cfg_reg.coef_u_to_blue  <= COEF_U_TO_BLUE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/yqr_prep.sv */
// ============================================================================
// yqr_prep
// First pipeline stage: sample width reduction and offset removal.
// ============================================================================
module yqr_prep
    import yqr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    yqr_stream_if.sink   src,
    yqr_stream_if.source dst
);

    logic    valid_reg;
    prep_t   prep_reg;
    prep_t   prep_next;
    off_t    luma_offset;
    sample_t luma_raw [4];

    // Drops the two low bits in 10-bit mode and subtracts the offset.
    function automatic off_t center(sample_t raw, logic ten_bit, off_t offset);
        sample_t s;
        s = ten_bit ? {2'b00, raw[SAMPLE_W-1:2]} : raw;
        return off_t'({1'b0, s}) - offset;
    endfunction

    assign luma_raw[0] = src.data.luma_top_left;
    assign luma_raw[1] = src.data.luma_top_right;
    assign luma_raw[2] = src.data.luma_bottom_left;
    assign luma_raw[3] = src.data.luma_bottom_right;

    assign luma_offset = cfg.full_range ? LUMA_OFFSET_FULL : LUMA_OFFSET_LIMITED;

    // Offset samples of the incoming quad.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prep_next.y[i] = center(luma_raw[i], cfg.ten_bit_mode, luma_offset);
        end
        prep_next.u = center(src.data.chroma_u, cfg.ten_bit_mode, CHROMA_ZERO);
        prep_next.v = center(src.data.chroma_v, cfg.ten_bit_mode, CHROMA_ZERO);
    end

    // Stage accepts when empty or when its contents move on.
    assign src.ready = !valid_reg || dst.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (src.ready)
        begin
            valid_reg <= src.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src.valid && src.ready)
        begin
            prep_reg <= prep_next;
        end
    end

    assign dst.valid = valid_reg;
    assign dst.data  = prep_reg;

`ifndef SYNTH
    // In 10-bit mode the centred chroma cannot exceed 127.
    a_ten_bit_chroma: assert property (@(posedge clk) disable iff (!rst_n)
        (src.valid && src.ready && cfg.ten_bit_mode)
        |=> (prep_reg.u <= 11'sd127 && prep_reg.v <= 11'sd127))
        else $error("chroma out of 8-bit range in 10-bit mode");
`endif

endmodule

/* hw/rtl/yqr_mult.sv */
// ============================================================================
// yqr_mult
// Second pipeline stage: eight signed 11 by 19 bit coefficient products.
// ============================================================================
module yqr_mult
    import yqr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    yqr_stream_if.sink   src,
    yqr_stream_if.source dst
);

    logic      valid_reg;
    prod_set_t prod_reg;
    prod_set_t prod_next;

    // Luma products for the four pixels and the four chroma products.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            prod_next.y[i] = prod_t'(src.data.y[i]) * prod_t'(cfg.coef_luma);
        end
        prod_next.vr = prod_t'(src.data.v) * prod_t'(cfg.coef_v_to_red);
        prod_next.ug = prod_t'(src.data.u) * prod_t'(cfg.coef_u_to_green);
        prod_next.vg = prod_t'(src.data.v) * prod_t'(cfg.coef_v_to_green);
        prod_next.ub = prod_t'(src.data.u) * prod_t'(cfg.coef_u_to_blue);
    end

    assign src.ready = !valid_reg || dst.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (src.ready)
        begin
            valid_reg <= src.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src.valid && src.ready)
        begin
            prod_reg <= prod_next;
        end
    end

    assign dst.valid = valid_reg;
    assign dst.data  = prod_reg;

endmodule

/* hw/rtl/yqr_post.sv */
// ============================================================================
// yqr_post
// Third and fourth pipeline stages: channel sums, then scaling and
// saturation into the output register.
// ============================================================================
module yqr_post
    import yqr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    yqr_stream_if.sink   src,
    yqr_stream_if.source dst
);

    logic     sum_valid_reg;
    sum_set_t sum_reg;
    sum_set_t sum_next;
    logic     sum_ready;
    logic     out_valid_reg;
    rgb_t     out_reg;
    rgb_t     out_next;

    // Floor of sum / 2^16, clamped to 0..255.
    function automatic pix_t saturate(sum_t s);
        pix_t p;
        if (s[SUM_W-1])
        begin
            p = PIX_MIN;
        end
        else if (|s[SUM_W-2:FRAC_BITS+PIX_W])
        begin
            p = PIX_MAX;
        end
        else
        begin
            p = s[FRAC_BITS+PIX_W-1:FRAC_BITS];
        end
        return p;
    endfunction

    // Sum stage: luma term plus the chroma terms of each channel.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sum_next.r[i] = sum_t'(src.data.y[i]) + sum_t'(src.data.vr);
            sum_next.g[i] = sum_t'(src.data.y[i]) + sum_t'(src.data.ug)
                          + sum_t'(src.data.vg);
            sum_next.b[i] = sum_t'(src.data.y[i]) + sum_t'(src.data.ub);
        end
    end

    assign src.ready = !sum_valid_reg || sum_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (src.ready)
        begin
            sum_valid_reg <= src.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src.valid && src.ready)
        begin
            sum_reg <= sum_next;
        end
    end

    // Saturation stage feeding the output register.
    always_comb
    begin
        out_next.red_top_left       = saturate(sum_reg.r[0]);
        out_next.green_top_left     = saturate(sum_reg.g[0]);
        out_next.blue_top_left      = saturate(sum_reg.b[0]);
        out_next.red_top_right      = saturate(sum_reg.r[1]);
        out_next.green_top_right    = saturate(sum_reg.g[1]);
        out_next.blue_top_right     = saturate(sum_reg.b[1]);
        out_next.red_bottom_left    = saturate(sum_reg.r[2]);
        out_next.green_bottom_left  = saturate(sum_reg.g[2]);
        out_next.blue_bottom_left   = saturate(sum_reg.b[2]);
        out_next.red_bottom_right   = saturate(sum_reg.r[3]);
        out_next.green_bottom_right = saturate(sum_reg.g[3]);
        out_next.blue_bottom_right  = saturate(sum_reg.b[3]);
    end

    assign sum_ready = !out_valid_reg || dst.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sum_ready)
        begin
            out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_valid_reg && sum_ready)
        begin
            out_reg <= out_next;
        end
    end

    assign dst.valid = out_valid_reg;
    assign dst.data  = out_reg;

`ifndef SYNTH
    // A negative red sum of the top left pixel must come out as zero.
    a_neg_clamps_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_valid_reg && sum_ready && sum_reg.r[0][SUM_W-1])
        |=> (dst.valid && dst.data.red_top_left == PIX_MIN))
        else $error("negative sum not clamped to zero");
`endif

endmodule
